FILE: sv/mrr_pkg.sv
// Shared codes and types for the two-pin motor ramp reverser.
// Holds the command and register codes and the configuration and result bundles.
// No dependencies.
package mrr_pkg;

	// Configuration register indexes
	localparam logic [1:0] REG_STEP_SIZE      = 2'd0;
	localparam logic [1:0] REG_TICKS_PER_STEP = 2'd1;
	localparam logic [1:0] REG_LIGHTS_PRESENT = 2'd2;

	// Request commands; codes 5 to 7 are spare and ignored
	typedef enum logic [2:0] {
		CMD_TICK         = 3'd0,
		CMD_SET_SPEED    = 3'd1,
		CMD_ENABLE       = 3'd2,
		CMD_DISABLE      = 3'd3,
		CMD_STOP_DISABLE = 3'd4,
		CMD_SPARE_5      = 3'd5,
		CMD_SPARE_6      = 3'd6,
		CMD_SPARE_7      = 3'd7
	} cmd_t;

	typedef struct packed {
		logic [7:0]  step_size;
		logic [15:0] ticks_per_step;
		logic        lights_present;
	} cfg_t;

	typedef struct packed {
		logic [7:0] drive_forward;
		logic [7:0] drive_reverse;
		logic       front_light;
		logic       rear_light;
		logic [7:0] present_speed;
		logic       running_reverse;
		logic       is_enabled;
		logic       is_ramping;
	} result_t;

endpackage

FILE: sv/mrr_core.sv
// Ramp state and next-state logic of the motor ramp reverser.
// Applies one request per fire strobe and presents the resulting pin/status bundle.
// Depends on mrr_pkg.
module mrr_core #(
	parameter int PWM_MAX = 255
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  logic [2:0]       cmd,
	input  logic [8:0]       req,
	input  mrr_pkg::cfg_t    cfg,
	output mrr_pkg::result_t res
);

	localparam int         LimInt = (PWM_MAX < 255) ? PWM_MAX : 255;
	localparam logic [8:0] Lim    = 9'(LimInt);
	localparam logic [15:0] PwmMax = 16'(PWM_MAX);

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_RAMP = 2'd1,
		PH_DOWN = 2'd2
	} phase_t;

	logic [7:0]  speed_now_q, speed_now_d;
	logic [7:0]  speed_goal_q, speed_goal_d;
	logic        reverse_now_q, reverse_now_d;
	logic        reverse_goal_q, reverse_goal_d;
	logic        enabled_q, enabled_d;
	phase_t      phase_q, phase_d;
	logic [15:0] tick_count_q, tick_count_d;
	logic        stop_pend_q, stop_pend_d;
	logic [1:0]  lamp_q, lamp_d;

	logic [7:0]  amt;
	logic [15:0] period;
	logic [15:0] tick_inc;
	logic [8:0]  mag_raw;
	logic [7:0]  req_mag;
	logic        req_rev;
	logic        ramp_end;
	logic [15:0] duty;

	// Move cur toward tgt by amt, stopping exactly at tgt
	function automatic logic [7:0] move_toward(input logic [7:0] cur, input logic [7:0] tgt,
			input logic [7:0] step);
		logic [7:0] r;
		r = cur;
		if (cur < tgt) begin
			r = ((tgt - cur) < step) ? tgt : cur + step;
		end else if (cur > tgt) begin
			r = ((cur - tgt) < step) ? tgt : cur - step;
		end
		return r;
	endfunction

	// Decode request magnitude and saturate; treat zero step size and period as one
	always_comb begin
		amt     = (cfg.step_size == 8'd0) ? 8'd1 : cfg.step_size;
		period  = (cfg.ticks_per_step == 16'd0) ? 16'd1 : cfg.ticks_per_step;
		mag_raw = req[8] ? (9'd0 - req) : req;
		if (mag_raw > Lim) begin
			mag_raw = Lim;
		end
		if (cmd == mrr_pkg::CMD_STOP_DISABLE) begin
			req_mag = 8'd0;
			req_rev = 1'b0;
		end else begin
			req_mag = mag_raw[7:0];
			req_rev = req[8];
		end
		tick_inc = tick_count_q + 16'd1;
	end

	// Next state
	always_comb begin
		speed_now_d    = speed_now_q;
		speed_goal_d   = speed_goal_q;
		reverse_now_d  = reverse_now_q;
		reverse_goal_d = reverse_goal_q;
		enabled_d      = enabled_q;
		phase_d        = phase_q;
		tick_count_d   = tick_count_q;
		stop_pend_d    = stop_pend_q;
		lamp_d         = lamp_q;
		ramp_end       = 1'b0;

		case (cmd)
			mrr_pkg::CMD_TICK: begin
				if (phase_q != PH_IDLE) begin
					if (tick_inc < period) begin
						tick_count_d = tick_inc;
					end else begin
						tick_count_d = 16'd0;
						if (phase_q == PH_DOWN) begin
							speed_now_d = move_toward(speed_now_q, 8'd0, amt);
							if (speed_now_d == 8'd0) begin
								reverse_now_d = reverse_goal_q;
								if (speed_goal_q == 8'd0) begin
									ramp_end = 1'b1;
								end else begin
									phase_d = PH_RAMP;
								end
							end
						end else begin
							speed_now_d = move_toward(speed_now_q, speed_goal_q, amt);
							if (speed_now_d == speed_goal_q) begin
								ramp_end = 1'b1;
							end
						end
						if (ramp_end) begin
							phase_d = PH_IDLE;
							if (stop_pend_q) begin
								enabled_d   = 1'b0;
								stop_pend_d = 1'b0;
							end
						end
					end
				end
			end
			mrr_pkg::CMD_SET_SPEED, mrr_pkg::CMD_STOP_DISABLE: begin
				// Take a new goal only when it differs from the current one
				if (req_mag != speed_goal_q || req_rev != reverse_goal_q) begin
					if (cfg.lights_present) begin
						lamp_d = req_rev ? 2'b10 : 2'b01;
					end
					speed_goal_d   = req_mag;
					reverse_goal_d = req_rev;
					enabled_d      = 1'b1;
					stop_pend_d    = 1'b0;
					tick_count_d   = 16'd0;
					if (req_rev != reverse_now_q && speed_now_q == 8'd0) begin
						reverse_now_d = req_rev;
					end
					if (req_rev != reverse_now_d) begin
						phase_d = PH_DOWN;
					end else if (speed_now_q != req_mag) begin
						phase_d = PH_RAMP;
					end else begin
						phase_d = PH_IDLE;
					end
				end
				if (cmd == mrr_pkg::CMD_STOP_DISABLE) begin
					if (phase_d == PH_IDLE) begin
						enabled_d   = 1'b0;
						stop_pend_d = 1'b0;
					end else begin
						stop_pend_d = 1'b1;
					end
				end
			end
			mrr_pkg::CMD_ENABLE: begin
				enabled_d   = 1'b1;
				stop_pend_d = 1'b0;
			end
			mrr_pkg::CMD_DISABLE: begin
				enabled_d   = 1'b0;
				stop_pend_d = 1'b0;
			end
			default: begin
			end
		endcase
	end

	// Hold state between requests, advance on fire
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_now_q    <= 8'd0;
			speed_goal_q   <= 8'd0;
			reverse_now_q  <= 1'b0;
			reverse_goal_q <= 1'b0;
			enabled_q      <= 1'b0;
			phase_q        <= PH_IDLE;
			tick_count_q   <= 16'd0;
			stop_pend_q    <= 1'b0;
			lamp_q         <= 2'b00;
		end else if (fire) begin
			speed_now_q    <= speed_now_d;
			speed_goal_q   <= speed_goal_d;
			reverse_now_q  <= reverse_now_d;
			reverse_goal_q <= reverse_goal_d;
			enabled_q      <= enabled_d;
			phase_q        <= phase_d;
			tick_count_q   <= tick_count_d;
			stop_pend_q    <= stop_pend_d;
			lamp_q         <= lamp_d;
		end
	end

	// Drive pins from the post-request state
	always_comb begin
		duty              = PwmMax - {8'd0, speed_now_d};
		res.drive_forward = PwmMax[7:0];
		res.drive_reverse = PwmMax[7:0];
		if (enabled_d) begin
			if (reverse_now_d) begin
				res.drive_reverse = duty[7:0];
			end else begin
				res.drive_forward = duty[7:0];
			end
		end
		res.front_light     = cfg.lights_present & lamp_d[0];
		res.rear_light      = cfg.lights_present & lamp_d[1];
		res.present_speed   = speed_now_d;
		res.running_reverse = reverse_now_d;
		res.is_enabled      = enabled_d;
		res.is_ramping      = (phase_d != PH_IDLE);
	end

endmodule

FILE: sv/two_pin_motor_ramp_reverser.sv
// Top level of the two-pin motor ramp reverser: request and result stages,
// configuration registers. Depends on mrr_pkg and mrr_core.
//
// Usage:
//   Requests (command, speed_request) enter on in_valid/in_ready. Each request
//   yields one result (both pin duties, lamps, speed, direction, enable, ramp
//   flag) on out_valid/out_ready, showing the state after that request.
//   Configuration is written through cfg_write_en/cfg_index/cfg_wdata while
//   no request is in flight; index 0 step size, 1 ticks per step, 2 lamps fitted.
//   An accepted request passes the request stage, then the core state and result
//   register, which raises out_valid; one request is taken every cycle while
//   out_ready is high, since the request stage advances into the core and result
//   register together. When the receiver stalls, the result register holds, the
//   request stage fills if empty, then in_ready drops until out_ready returns.
//   Reset clears both stages, returns the ramp state to standstill, forward,
//   disabled, lamps off, and reloads step size 4, ticks per step 8, no lamps.
module two_pin_motor_ramp_reverser #(
	parameter int PWM_MAX = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write_en,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  command,
	input  logic [8:0]  speed_request,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  drive_forward,
	output logic [7:0]  drive_reverse,
	output logic        front_light,
	output logic        rear_light,
	output logic [7:0]  present_speed,
	output logic        running_reverse,
	output logic        is_enabled,
	output logic        is_ramping
);

	mrr_pkg::cfg_t    cfg_q;
	mrr_pkg::result_t res;
	mrr_pkg::result_t res_q;

	logic       valid_s1;
	logic [2:0] cmd_s1;
	logic [8:0] req_s1;
	logic       out_valid_q;
	logic       advance;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_size      <= 8'd4;
			cfg_q.ticks_per_step <= 16'd8;
			cfg_q.lights_present <= 1'b0;
		end else if (cfg_write_en) begin
			case (cfg_index)
				mrr_pkg::REG_STEP_SIZE:      cfg_q.step_size      <= cfg_wdata[7:0];
				mrr_pkg::REG_TICKS_PER_STEP: cfg_q.ticks_per_step <= cfg_wdata;
				mrr_pkg::REG_LIGHTS_PRESENT: cfg_q.lights_present <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	// Capture request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1 <= command;
			req_s1 <= speed_request;
		end
	end

	mrr_core #(
		.PWM_MAX(PWM_MAX)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (advance),
		.cmd   (cmd_s1),
		.req   (req_s1),
		.cfg   (cfg_q),
		.res   (res)
	);

	// Hold result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid       = out_valid_q;
	assign drive_forward   = res_q.drive_forward;
	assign drive_reverse   = res_q.drive_reverse;
	assign front_light     = res_q.front_light;
	assign rear_light      = res_q.rear_light;
	assign present_speed   = res_q.present_speed;
	assign running_reverse = res_q.running_reverse;
	assign is_enabled      = res_q.is_enabled;
	assign is_ramping      = res_q.is_ramping;

endmodule

FILE: tb/sv/two_pin_motor_ramp_reverser_test.sv
// Self-checking testbench for two_pin_motor_ramp_reverser: directed drill, then randomized
// command streams under several ramp settings, with random idling on both channels.
// Depends on mrr_pkg and the two_pin_motor_ramp_reverser RTL.
module two_pin_motor_ramp_reverser_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PWM_TOP   = 255;
	localparam int SPEED_CAP = (PWM_TOP < 255) ? PWM_TOP : 255;
	localparam int CYCLE_LIMIT = 300000;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_RAMP = 2'd1,
		PH_DOWN = 2'd2
	} ramp_phase_t;

	typedef struct packed {
		mrr_pkg::cmd_t    cmd;
		logic [8:0]       req;
		logic             pinned;
		mrr_pkg::result_t want;
	} drill_row_t;

	typedef struct packed {
		logic [7:0]  step;
		logic [15:0] period;
		logic        lamps;
		logic [15:0] items;
	} ramp_setup_t;

	// Pinned results: standstill disabled, standstill enabled, reverse start from rest
	localparam mrr_pkg::result_t RES_STILL =
		'{8'd255, 8'd255, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0};
	localparam mrr_pkg::result_t RES_ON    =
		'{8'd255, 8'd255, 1'b0, 1'b0, 8'd0, 1'b0, 1'b1, 1'b0};
	localparam mrr_pkg::result_t RES_REV   =
		'{8'd255, 8'd255, 1'b0, 1'b0, 8'd0, 1'b1, 1'b1, 1'b1};

	// Directed drill under reset settings (step 4, 8 ticks per step, no lamps)
	localparam drill_row_t DRILL [0:24] = '{
		'{mrr_pkg::CMD_TICK,         9'h000, 1'b1, RES_STILL},
		'{mrr_pkg::CMD_SPARE_5,      9'h0FF, 1'b1, RES_STILL},
		'{mrr_pkg::CMD_SPARE_7,      9'h1FF, 1'b1, RES_STILL},
		'{mrr_pkg::CMD_ENABLE,       9'h000, 1'b1, RES_ON},
		'{mrr_pkg::CMD_DISABLE,      9'h000, 1'b1, RES_STILL},
		'{mrr_pkg::CMD_SET_SPEED,    9'h000, 1'b1, RES_STILL},
		'{mrr_pkg::CMD_SET_SPEED,    9'h100, 1'b1, RES_REV},
		'{mrr_pkg::CMD_TICK,         9'h000, 1'b0, RES_STILL},
		'{mrr_pkg::CMD_TICK,         9'h000, 1'b0, RES_STILL},
		'{mrr_pkg::CMD_TICK,         9'h000, 1'b0, RES_STILL},
		'{mrr_pkg::CMD_TICK,         9'h000, 1'b0, RES_STILL},
		'{mrr_pkg::CMD_TICK,         9'h000, 1'b0, RES_STILL},
		'{mrr_pkg::CMD_TICK,         9'h000, 1'b0, RES_STILL},
		'{mrr_pkg::CMD_TICK,         9'h000, 1'b0, RES_STILL},
		'{mrr_pkg::CMD_TICK,         9'h000, 1'b0, RES_STILL},
		'{mrr_pkg::CMD_SET_SPEED,    9'h0FF, 1'b0, RES_STILL},
		'{mrr_pkg::CMD_STOP_DISABLE, 9'h155, 1'b0, RES_STILL},
		'{mrr_pkg::CMD_TICK,         9'h000, 1'b0, RES_STILL},
		'{mrr_pkg::CMD_TICK,         9'h000, 1'b0, RES_STILL},
		'{mrr_pkg::CMD_TICK,         9'h000, 1'b0, RES_STILL},
		'{mrr_pkg::CMD_TICK,         9'h000, 1'b0, RES_STILL},
		'{mrr_pkg::CMD_TICK,         9'h000, 1'b0, RES_STILL},
		'{mrr_pkg::CMD_TICK,         9'h000, 1'b0, RES_STILL},
		'{mrr_pkg::CMD_TICK,         9'h000, 1'b0, RES_STILL},
		'{mrr_pkg::CMD_TICK,         9'h0AA, 1'b1, RES_STILL}
	};

	// Ramp settings walked by the random part, zero values and extremes included
	localparam ramp_setup_t RAMP_SETUPS [0:6] = '{
		'{8'd1,   16'd1,     1'b1, 16'd150},
		'{8'd255, 16'd1,     1'b1, 16'd140},
		'{8'd0,   16'd0,     1'b0, 16'd140},
		'{8'd7,   16'd3,     1'b1, 16'd150},
		'{8'd1,   16'd65535, 1'b1, 16'd40},
		'{8'd32,  16'd2,     1'b0, 16'd150},
		'{8'd4,   16'd8,     1'b1, 16'd150}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write_en = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  command = '0;
	logic [8:0]  speed_request = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  drive_forward;
	logic [7:0]  drive_reverse;
	logic        front_light;
	logic        rear_light;
	logic [7:0]  present_speed;
	logic        running_reverse;
	logic        is_enabled;
	logic        is_ramping;

	// Pinned expectation travels with the request payload
	logic              pinned_now = 1'b0;
	mrr_pkg::result_t  pinned_want = '0;

	mrr_pkg::result_t  due_drive_states [$];
	int          fails = 0;
	int          requests_taken = 0;
	int          cycles = 0;
	int          burst_left = 0;

	// Shadow of the ramp controller
	logic [7:0]  shadow_step = 8'd4;
	logic [15:0] shadow_period = 16'd8;
	logic        shadow_lamps = 1'b0;
	logic [7:0]  speed_now = '0;
	logic [7:0]  speed_goal = '0;
	logic        reverse_now = 1'b0;
	logic        reverse_goal = 1'b0;
	logic        bridge_on = 1'b0;
	logic        stop_pending = 1'b0;
	ramp_phase_t phase = PH_IDLE;
	logic [15:0] tick_count = '0;
	logic [1:0]  lamp_bits = '0;

	two_pin_motor_ramp_reverser #(.PWM_MAX(PWM_TOP)) u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_write_en    (cfg_write_en),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.command         (command),
		.speed_request   (speed_request),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.drive_forward   (drive_forward),
		.drive_reverse   (drive_reverse),
		.front_light     (front_light),
		.rear_light      (rear_light),
		.present_speed   (present_speed),
		.running_reverse (running_reverse),
		.is_enabled      (is_enabled),
		.is_ramping      (is_ramping)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Move cur toward tgt by amt, landing exactly on tgt
	function automatic logic [7:0] slew(input logic [7:0] cur, input logic [7:0] tgt,
			input logic [7:0] amt);
		if (cur < tgt)
			return (tgt - cur < amt) ? tgt : cur + amt;
		if (cur > tgt)
			return (cur - tgt < amt) ? tgt : cur - amt;
		return cur;
	endfunction

	function automatic void end_ramp();
		phase = PH_IDLE;
		tick_count = '0;
		if (stop_pending) begin
			bridge_on = 1'b0;
			stop_pending = 1'b0;
		end
	endfunction

	function automatic void aim_speed(input logic [7:0] mag, input logic rev);
		if (mag == speed_goal && rev == reverse_goal)
			return;
		if (shadow_lamps)
			lamp_bits = rev ? 2'b10 : 2'b01;
		speed_goal = mag;
		reverse_goal = rev;
		bridge_on = 1'b1;
		stop_pending = 1'b0;
		tick_count = '0;
		// From standstill the direction flips at once
		if (rev != reverse_now && speed_now == 8'd0)
			reverse_now = rev;
		if (rev != reverse_now)
			phase = PH_DOWN;
		else if (speed_now != mag)
			phase = PH_RAMP;
		else
			phase = PH_IDLE;
	endfunction

	function automatic void count_tick();
		logic [7:0]  amt;
		logic [15:0] period;
		amt = (shadow_step != 8'd0) ? shadow_step : 8'd1;
		period = (shadow_period != 16'd0) ? shadow_period : 16'd1;
		if (phase == PH_IDLE)
			return;
		tick_count = tick_count + 16'd1;
		if (tick_count < period)
			return;
		tick_count = '0;
		if (phase == PH_DOWN) begin
			speed_now = slew(speed_now, 8'd0, amt);
			if (speed_now == 8'd0) begin
				reverse_now = reverse_goal;
				if (speed_goal == 8'd0)
					end_ramp();
				else
					phase = PH_RAMP;
			end
		end else begin
			speed_now = slew(speed_now, speed_goal, amt);
			if (speed_now == speed_goal)
				end_ramp();
		end
	endfunction

	// Apply one request to the shadow and return the pin/status state after it
	function automatic mrr_pkg::result_t advance_motor(input mrr_pkg::cmd_t cmd,
			input logic [8:0] req);
		logic             neg;
		logic [9:0]       mag_wide;
		logic [7:0]       mag;
		logic [7:0]       duty;
		mrr_pkg::result_t r;
		neg = req[8];
		mag_wide = neg ? (10'd512 - {1'b0, req}) : {1'b0, req};
		mag = (mag_wide > SPEED_CAP) ? 8'(SPEED_CAP) : mag_wide[7:0];
		case (cmd)
			mrr_pkg::CMD_TICK: count_tick();
			mrr_pkg::CMD_SET_SPEED: aim_speed(mag, neg);
			mrr_pkg::CMD_ENABLE: begin
				bridge_on = 1'b1;
				stop_pending = 1'b0;
			end
			mrr_pkg::CMD_DISABLE: begin
				bridge_on = 1'b0;
				stop_pending = 1'b0;
			end
			mrr_pkg::CMD_STOP_DISABLE: begin
				aim_speed(8'd0, 1'b0);
				if (phase == PH_IDLE) begin
					bridge_on = 1'b0;
					stop_pending = 1'b0;
				end else begin
					stop_pending = 1'b1;
				end
			end
			default: ;
		endcase
		r.drive_forward = 8'(PWM_TOP);
		r.drive_reverse = 8'(PWM_TOP);
		if (bridge_on) begin
			duty = 8'(PWM_TOP - speed_now);
			if (reverse_now)
				r.drive_reverse = duty;
			else
				r.drive_forward = duty;
		end
		r.front_light = shadow_lamps & lamp_bits[0];
		r.rear_light = shadow_lamps & lamp_bits[1];
		r.present_speed = speed_now;
		r.running_reverse = reverse_now;
		r.is_enabled = bridge_on;
		r.is_ramping = (phase != PH_IDLE);
		return r;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fails++;
		end
	endtask

	task automatic compare_state(input mrr_pkg::result_t want, input mrr_pkg::result_t got);
		check_field("drive_forward", want.drive_forward, got.drive_forward);
		check_field("drive_reverse", want.drive_reverse, got.drive_reverse);
		check_field("front_light", want.front_light, got.front_light);
		check_field("rear_light", want.rear_light, got.rear_light);
		check_field("present_speed", want.present_speed, got.present_speed);
		check_field("running_reverse", want.running_reverse, got.running_reverse);
		check_field("is_enabled", want.is_enabled, got.is_enabled);
		check_field("is_ramping", want.is_ramping, got.is_ramping);
	endtask

	// Check results first, then record the request taken at the same edge
	always @(posedge clk) begin
		mrr_pkg::result_t seen;
		mrr_pkg::result_t forecast;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				seen = '{drive_forward, drive_reverse, front_light, rear_light,
					present_speed, running_reverse, is_enabled, is_ramping};
				if (due_drive_states.size() == 0) begin
					$error("result with no request outstanding");
					fails++;
				end else begin
					compare_state(due_drive_states.pop_front(), seen);
				end
			end
			if (in_valid && in_ready) begin
				requests_taken++;
				forecast = advance_motor(mrr_pkg::cmd_t'(command), speed_request);
				due_drive_states.push_back(pinned_now ? pinned_want : forecast);
			end
		end
	end

	// Bound the run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("two_pin_motor_ramp_reverser verification failed");
			$finish;
		end
	end

	// Receiver: stall patterns in stretches, plus one long hold-off to back up the input
	initial begin
		int  style;
		int  len;
		int  beat;
		bit  held_off;
		beat = 0;
		held_off = 1'b0;
		@(posedge arst_n);
		forever begin
			style = $urandom_range(0, 3);
			len = $urandom_range(16, 80);
			repeat (len) begin
				@(posedge clk);
				beat++;
				if (!held_off && requests_taken >= 300) begin
					held_off = 1'b1;
					out_ready <= 1'b0;
					repeat (400) @(posedge clk);
				end else begin
					case (style)
						0: out_ready <= 1'b1;
						1: out_ready <= ($urandom_range(0, 3) != 0);
						2: out_ready <= ($urandom_range(0, 3) == 0);
						default: out_ready <= beat[1];
					endcase
				end
			end
		end
	end

	// Offer one request, idling first when the current burst is used up
	task automatic offer_item(input mrr_pkg::cmd_t c, input logic [8:0] r, input logic pin,
			input mrr_pkg::result_t want);
		int gap;
		if (burst_left == 0) begin
			if ($urandom_range(0, 7) == 0) begin
				burst_left = 150;
				gap = 0;
			end else begin
				burst_left = $urandom_range(1, 24);
				gap = $urandom_range(0, 6);
			end
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b1;
		command <= c;
		speed_request <= r;
		pinned_now <= pin;
		pinned_want <= want;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		burst_left--;
	endtask

	// Drop valid and wait until every outstanding result has come back
	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		do
			@(posedge clk);
		while (due_drive_states.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			mrr_pkg::REG_STEP_SIZE: shadow_step = val[7:0];
			mrr_pkg::REG_TICKS_PER_STEP: shadow_period = val;
			mrr_pkg::REG_LIGHTS_PRESENT: shadow_lamps = val[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Speed requests: repeats of the goal, zero, extremes, small values, noise
	function automatic logic [8:0] pick_speed();
		int roll;
		roll = $urandom_range(0, 9);
		case (roll)
			0: return reverse_goal ? (9'd0 - {1'b0, speed_goal}) : {1'b0, speed_goal};
			1: return 9'h000;
			2: return 9'h100;
			3: return $urandom_range(0, 1) ? 9'h0FF : 9'h101;
			4, 5, 6: return $urandom_range(0, 1) ? 9'($urandom_range(1, 20))
				: 9'd0 - 9'($urandom_range(1, 20));
			default: return 9'($urandom_range(0, 511));
		endcase
	endfunction

	task automatic pick_item(output mrr_pkg::cmd_t c, output logic [8:0] r);
		int roll;
		roll = $urandom_range(0, 99);
		r = 9'($urandom_range(0, 511));
		if (roll < 58)
			c = mrr_pkg::CMD_TICK;
		else if (roll < 78) begin
			c = mrr_pkg::CMD_SET_SPEED;
			r = pick_speed();
		end else if (roll < 84)
			c = mrr_pkg::CMD_ENABLE;
		else if (roll < 90)
			c = mrr_pkg::CMD_DISABLE;
		else if (roll < 95)
			c = mrr_pkg::CMD_STOP_DISABLE;
		else
			c = mrr_pkg::cmd_t'($urandom_range(5, 7));
	endtask

	initial begin
		mrr_pkg::cmd_t c;
		logic [8:0]    r;
		int            left;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed drill under reset settings
		foreach (DRILL[i])
			offer_item(DRILL[i].cmd, DRILL[i].req, DRILL[i].pinned, DRILL[i].want);

		// Random command streams, one ramp setting at a time
		foreach (RAMP_SETUPS[p]) begin
			drain();
			write_reg(mrr_pkg::REG_STEP_SIZE, {8'($urandom), RAMP_SETUPS[p].step});
			write_reg(mrr_pkg::REG_TICKS_PER_STEP, RAMP_SETUPS[p].period);
			write_reg(mrr_pkg::REG_LIGHTS_PRESENT, {15'($urandom), RAMP_SETUPS[p].lamps});
			cfg_write_en <= 1'b0;
			left = int'(RAMP_SETUPS[p].items);
			while (left > 0) begin
				pick_item(c, r);
				offer_item(c, r, 1'b0, RES_STILL);
				if (c < mrr_pkg::CMD_SPARE_5)
					left--;
			end
		end

		drain();
		if (fails == 0)
			$display("two_pin_motor_ramp_reverser verification clean");
		else
			$display("two_pin_motor_ramp_reverser verification failed");
		$finish;
	end

endmodule
